/* rtl/prot_pkg.sv */
// Shared types and constants for the plane rotation block.
`default_nettype none

package prot_pkg;

    localparam int SIDE_CFG_W   = 9;
    localparam int MODE_CFG_W   = 2;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_INDEX_W  = 2;
    localparam int PIXEL_PORT_W = 32;

    localparam logic [SIDE_CFG_W-1:0] SIDE_RESET = 9'd256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PLANE_COLS  = 2'd0,
        REG_PLANE_ROWS  = 2'd1,
        REG_ROTATE_MODE = 2'd2
    } cfg_index_t;

    typedef enum logic [MODE_CFG_W-1:0] {
        ROT_LEFT  = 2'd0,
        ROT_RIGHT = 2'd1,
        ROT_HALF  = 2'd2
    } rot_mode_t;

    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_PULL  = 1'b1;

    typedef enum logic {
        PH_LOAD  = 1'b0,
        PH_DRAIN = 1'b1
    } phase_t;

    typedef struct packed {
        logic store;
        logic pull;
        logic last;
    } pipe_ctrl_t;

    localparam pipe_ctrl_t PIPE_IDLE = '{store: 1'b0, pull: 1'b0, last: 1'b0};

endpackage

`default_nettype wire

/* rtl/prot_seq.sv */
// Configuration registers, load/drain sequencer and source coordinate stage.
`default_nettype none

module prot_seq #(
    parameter int MAX_SIDE   = 256,
    parameter int PIXEL_BITS = 32
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     adv,
    input  wire logic                                     in_valid,
    input  wire logic                                     req_type,
    input  wire logic [prot_pkg::PIXEL_PORT_W-1:0]        pixel_in,
    input  wire logic                                     wr_en,
    input  wire logic [prot_pkg::CFG_INDEX_W-1:0]         wr_index,
    input  wire logic [prot_pkg::CFG_DATA_W-1:0]          wr_data,
    output prot_pkg::pipe_ctrl_t                          s1_ctrl,
    output logic [$clog2(MAX_SIDE)-1:0]                   s1_src_r,
    output logic [$clog2(MAX_SIDE)-1:0]                   s1_src_c,
    output logic [$clog2(MAX_SIDE+1)-1:0]                 s1_cols,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]          s1_waddr,
    output logic [PIXEL_BITS-1:0]                         s1_data
);
    import prot_pkg::*;

    localparam int SW    = $clog2(MAX_SIDE);
    localparam int NW    = $clog2(MAX_SIDE + 1);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = AW + 1;
    localparam int TW    = 2 * NW;
    localparam int CW    = (LW > TW) ? LW : TW;
    localparam int XW    = (NW > SIDE_CFG_W) ? NW : SIDE_CFG_W;

    logic [SIDE_CFG_W-1:0] cols_cfg_reg;
    logic [SIDE_CFG_W-1:0] rows_cfg_reg;
    logic [MODE_CFG_W-1:0] mode_reg;

    phase_t        phase_reg, phase_next;
    logic [LW-1:0] load_count_reg, load_count_next;
    logic [SW-1:0] out_row_reg, out_row_next;
    logic [SW-1:0] out_col_reg, out_col_next;

    pipe_ctrl_t    s1_ctrl_reg, s1_ctrl_next;
    logic [SW-1:0] s1_src_r_reg, s1_src_r_next;
    logic [SW-1:0] s1_src_c_reg, s1_src_c_next;
    logic [NW-1:0] s1_cols_reg;
    logic [AW-1:0] s1_waddr_reg;
    logic [PIXEL_BITS-1:0] s1_data_reg;

    logic [XW-1:0] cols_x, rows_x;
    logic [NW-1:0] cols_w, rows_w;
    logic [NW-1:0] cols_m1, rows_m1;
    logic [NW-1:0] ow, oh;
    logic [NW-1:0] col_inc, row_inc;
    logic [NW-1:0] src_r_full, src_c_full;
    logic [TW-1:0] total;
    logic [LW-1:0] load_inc;
    logic          load_done;
    logic          col_wrap, row_wrap, last;
    logic          accept, is_store, is_pull;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= SIDE_RESET;
            rows_cfg_reg <= SIDE_RESET;
            mode_reg     <= ROT_LEFT;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_PLANE_COLS:  cols_cfg_reg <= wr_data;
                REG_PLANE_ROWS:  rows_cfg_reg <= wr_data;
                REG_ROTATE_MODE: mode_reg     <= wr_data[MODE_CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    // clamp sides to 1..MAX_SIDE
    always_comb
    begin
        cols_x = XW'(cols_cfg_reg);
        rows_x = XW'(rows_cfg_reg);
        if (cols_x == '0)
            cols_w = NW'(1);
        else if (cols_x > XW'(MAX_SIDE))
            cols_w = NW'(MAX_SIDE);
        else
            cols_w = cols_x[NW-1:0];
        if (rows_x == '0)
            rows_w = NW'(1);
        else if (rows_x > XW'(MAX_SIDE))
            rows_w = NW'(MAX_SIDE);
        else
            rows_w = rows_x[NW-1:0];
    end

    assign cols_m1   = cols_w - NW'(1);
    assign rows_m1   = rows_w - NW'(1);
    assign total     = TW'(cols_w) * TW'(rows_w);
    assign load_inc  = load_count_reg + LW'(1);
    assign load_done = CW'(load_inc) >= CW'(total);

    always_comb
    begin
        unique case (mode_reg)
            ROT_LEFT:
            begin
                ow         = rows_w;
                oh         = cols_w;
                src_r_full = NW'(out_col_reg);
                src_c_full = cols_m1 - NW'(out_row_reg);
            end
            ROT_RIGHT:
            begin
                ow         = rows_w;
                oh         = cols_w;
                src_r_full = rows_m1 - NW'(out_col_reg);
                src_c_full = NW'(out_row_reg);
            end
            default:
            begin
                ow         = cols_w;
                oh         = rows_w;
                src_r_full = rows_m1 - NW'(out_row_reg);
                src_c_full = cols_m1 - NW'(out_col_reg);
            end
        endcase
    end

    assign col_inc  = NW'(out_col_reg) + NW'(1);
    assign row_inc  = NW'(out_row_reg) + NW'(1);
    assign col_wrap = col_inc >= ow;
    assign row_wrap = row_inc >= oh;
    assign last     = col_wrap && row_wrap;

    assign accept   = in_valid && adv;
    assign is_store = accept && (phase_reg == PH_LOAD) && (req_type == REQ_STORE);
    assign is_pull  = accept && (phase_reg == PH_DRAIN) && (req_type == REQ_PULL);

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        load_count_next = load_count_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        unique case (phase_reg)
            PH_LOAD:
            begin
                if (is_store)
                begin
                    load_count_next = load_inc;
                    if (load_done)
                    begin
                        phase_next   = PH_DRAIN;
                        out_row_next = '0;
                        out_col_next = '0;
                    end
                end
            end
            PH_DRAIN:
            begin
                if (is_pull)
                begin
                    if (col_wrap)
                    begin
                        out_col_next = '0;
                        out_row_next = row_wrap ? '0 : row_inc[SW-1:0];
                    end
                    else
                    begin
                        out_col_next = col_inc[SW-1:0];
                    end
                    if (last)
                    begin
                        phase_next      = PH_LOAD;
                        load_count_next = '0;
                    end
                end
            end
        endcase
    end

    // stage outputs
    always_comb
    begin
        s1_ctrl_next.store = is_store;
        s1_ctrl_next.pull  = is_pull;
        s1_ctrl_next.last  = is_pull && last;
        s1_src_r_next      = src_r_full[SW-1:0];
        s1_src_c_next      = src_c_full[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LOAD;
            load_count_reg <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            s1_ctrl_reg    <= PIPE_IDLE;
        end
        else
        begin
            phase_reg      <= phase_next;
            load_count_reg <= load_count_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
            if (adv)
                s1_ctrl_reg <= s1_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_src_r_reg <= s1_src_r_next;
            s1_src_c_reg <= s1_src_c_next;
            s1_cols_reg  <= cols_w;
            s1_waddr_reg <= load_count_reg[AW-1:0];
            s1_data_reg  <= pixel_in[PIXEL_BITS-1:0];
        end
    end

    assign s1_ctrl  = s1_ctrl_reg;
    assign s1_src_r = s1_src_r_reg;
    assign s1_src_c = s1_src_c_reg;
    assign s1_cols  = s1_cols_reg;
    assign s1_waddr = s1_waddr_reg;
    assign s1_data  = s1_data_reg;

    a_last_reloads: assert property (@(posedge clk) disable iff (!rst_n)
        is_pull && last |=> phase_reg == PH_LOAD && load_count_reg == '0)
        else $error("plane end did not return to loading");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LOAD |-> load_count_reg <= LW'(DEPTH))
        else $error("load count beyond store depth");

    a_load_origin: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LOAD |-> out_row_reg == '0 && out_col_reg == '0)
        else $error("output position not at origin while loading");

    a_stage_kind: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({s1_ctrl_reg.store, s1_ctrl_reg.pull})
        && (s1_ctrl_reg.last -> s1_ctrl_reg.pull))
        else $error("stage carries both store and pull");

endmodule

`default_nettype wire

/* rtl/prot_addr.sv */
// Store address stage: row times width plus column for pulls.
`default_nettype none

module prot_addr #(
    parameter int MAX_SIDE   = 256,
    parameter int PIXEL_BITS = 32
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     adv,
    input  wire prot_pkg::pipe_ctrl_t                     s1_ctrl,
    input  wire logic [$clog2(MAX_SIDE)-1:0]              s1_src_r,
    input  wire logic [$clog2(MAX_SIDE)-1:0]              s1_src_c,
    input  wire logic [$clog2(MAX_SIDE+1)-1:0]            s1_cols,
    input  wire logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]     s1_waddr,
    input  wire logic [PIXEL_BITS-1:0]                    s1_data,
    output prot_pkg::pipe_ctrl_t                          s2_ctrl,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]          s2_addr,
    output logic [PIXEL_BITS-1:0]                         s2_data
);
    import prot_pkg::*;

    localparam int SW = $clog2(MAX_SIDE);
    localparam int NW = $clog2(MAX_SIDE + 1);
    localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int PW = SW + NW;

    pipe_ctrl_t        s2_ctrl_reg;
    logic [AW-1:0]     s2_addr_reg, s2_addr_next;
    logic [PIXEL_BITS-1:0] s2_data_reg;
    logic [PW-1:0]     raddr_full;

    assign raddr_full   = PW'(s1_src_r) * PW'(s1_cols) + PW'(s1_src_c);
    assign s2_addr_next = s1_ctrl.store ? s1_waddr : raddr_full[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_ctrl_reg <= PIPE_IDLE;
        else if (adv)
            s2_ctrl_reg <= s1_ctrl;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_addr_reg <= s2_addr_next;
            s2_data_reg <= s1_data;
        end
    end

    assign s2_ctrl = s2_ctrl_reg;
    assign s2_addr = s2_addr_reg;
    assign s2_data = s2_data_reg;

endmodule

`default_nettype wire

/* rtl/prot_store.sv */
// Plane store memory with registered read feeding the result register.
`default_nettype none

module prot_store #(
    parameter int MAX_SIDE   = 256,
    parameter int PIXEL_BITS = 32
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     adv,
    input  wire prot_pkg::pipe_ctrl_t                     s2_ctrl,
    input  wire logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]     s2_addr,
    input  wire logic [PIXEL_BITS-1:0]                    s2_data,
    output logic                                          out_valid,
    output logic [prot_pkg::PIXEL_PORT_W-1:0]             pixel_out,
    output logic                                          plane_end
);
    import prot_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;

    logic [PIXEL_BITS-1:0] mem [DEPTH];
    logic [PIXEL_BITS-1:0] rd_data_reg;
    logic                  out_valid_reg;
    logic                  last_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s2_ctrl.store)
                mem[s2_addr] <= s2_data;
            if (s2_ctrl.pull)
                rd_data_reg <= mem[s2_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s2_ctrl.pull;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            last_reg <= s2_ctrl.last;
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = PIXEL_PORT_W'(rd_data_reg);
    assign plane_end = last_reg;

endmodule

`default_nettype wire

/* rtl/plane_rotate_90_180.sv */
// Top level of the plane rotation block: one plane store, left/right/180 readout.
// A pull is registered at the sequencer, address and store read stages in turn.
// Throughput: one transfer per cycle on either side, one store port access per item,
// bar stalls. Input stall rises only while a finished pixel waits on a stalled output.
// Reset clears the sequencer, configuration and pipeline valids; store contents
// stay undefined until written and get no clearing pass.
`default_nettype none

module plane_rotate_90_180 #(
    parameter int MAX_SIDE   = 256,
    parameter int PIXEL_BITS = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 req_type,
    input  wire logic [prot_pkg::PIXEL_PORT_W-1:0]    pixel_in,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [prot_pkg::PIXEL_PORT_W-1:0]         pixel_out,
    output logic                                      plane_end,
    input  wire logic                                 wr_en,
    input  wire logic [prot_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  wire logic [prot_pkg::CFG_DATA_W-1:0]      wr_data
);
    import prot_pkg::*;

    localparam int SW = $clog2(MAX_SIDE);
    localparam int NW = $clog2(MAX_SIDE + 1);
    localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);

    logic          adv;
    logic          out_valid_w;
    pipe_ctrl_t    s1_ctrl, s2_ctrl;
    logic [SW-1:0] s1_src_r, s1_src_c;
    logic [NW-1:0] s1_cols;
    logic [AW-1:0] s1_waddr, s2_addr;
    logic [PIXEL_BITS-1:0] s1_data, s2_data;

    // advance the whole pipe unless a result is held
    assign adv       = !(out_valid_w && out_stall);
    assign in_stall  = !adv;
    assign out_valid = out_valid_w;

    prot_seq #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .req_type (req_type),
        .pixel_in (pixel_in),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s1_ctrl  (s1_ctrl),
        .s1_src_r (s1_src_r),
        .s1_src_c (s1_src_c),
        .s1_cols  (s1_cols),
        .s1_waddr (s1_waddr),
        .s1_data  (s1_data)
    );

    prot_addr #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_addr (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .s1_ctrl  (s1_ctrl),
        .s1_src_r (s1_src_r),
        .s1_src_c (s1_src_c),
        .s1_cols  (s1_cols),
        .s1_waddr (s1_waddr),
        .s1_data  (s1_data),
        .s2_ctrl  (s2_ctrl),
        .s2_addr  (s2_addr),
        .s2_data  (s2_data)
    );

    prot_store #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .s2_ctrl   (s2_ctrl),
        .s2_addr   (s2_addr),
        .s2_data   (s2_data),
        .out_valid (out_valid_w),
        .pixel_out (pixel_out),
        .plane_end (plane_end)
    );

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for plane_rotate_90_180 with directed and random plane traffic.
module tb;
    import prot_pkg::*;

    localparam int MAX_SIDE = 256;
    localparam int STORE_WORDS = MAX_SIDE * MAX_SIDE;
    localparam logic [MODE_CFG_W-1:0] ROT_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS = 75;

    typedef struct packed {
        logic [PIXEL_PORT_W-1:0] pixel;
        logic                    last;
    } pixel_rec_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    req_type = REQ_STORE;
    logic [PIXEL_PORT_W-1:0] pixel_in = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [PIXEL_PORT_W-1:0] pixel_out;
    logic                    plane_end;
    logic                    wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]  wr_index = REG_PLANE_COLS;
    logic [CFG_DATA_W-1:0]   wr_data = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;
    int items_sent = 0;
    int pixels_checked = 0;
    int planes_done = 0;

    logic [PIXEL_PORT_W-1:0] plane_mem [STORE_WORDS];
    logic [16:0]             fill_count = '0;
    phase_t                  plane_phase = PH_LOAD;
    int unsigned             rd_row = 0;
    int unsigned             rd_col = 0;
    logic [SIDE_CFG_W-1:0]   cfg_cols = SIDE_RESET;
    logic [SIDE_CFG_W-1:0]   cfg_rows = SIDE_RESET;
    logic [MODE_CFG_W-1:0]   cfg_mode = ROT_LEFT;

    pixel_rec_t rotated_pixels[$];
    pixel_rec_t want;

    plane_rotate_90_180 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out),
        .plane_end (plane_end),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned eff_side(logic [SIDE_CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return v;
    endfunction

    function automatic void rotate_track(logic rt, logic [PIXEL_PORT_W-1:0] px);
        int unsigned cols, rows, total, ow, oh, src_r, src_c, addr;
        logic last;
        cols = eff_side(cfg_cols);
        rows = eff_side(cfg_rows);
        total = cols * rows;
        if (plane_phase == PH_LOAD)
        begin
            if (rt == REQ_STORE)
            begin
                plane_mem[fill_count % STORE_WORDS] = px;
                fill_count = fill_count + 1'b1;
                if (fill_count >= total)
                begin
                    plane_phase = PH_DRAIN;
                    rd_row = 0;
                    rd_col = 0;
                end
            end
        end
        else if (rt == REQ_PULL)
        begin
            case (cfg_mode)
                ROT_LEFT:
                begin
                    ow = rows;
                    oh = cols;
                    src_r = rd_col;
                    src_c = cols - 1 - rd_row;
                end
                ROT_RIGHT:
                begin
                    ow = rows;
                    oh = cols;
                    src_r = rows - 1 - rd_col;
                    src_c = rd_row;
                end
                default:
                begin
                    ow = cols;
                    oh = rows;
                    src_r = rows - 1 - rd_row;
                    src_c = cols - 1 - rd_col;
                end
            endcase
            addr = (src_r * cols + src_c) % STORE_WORDS;
            last = 1'b0;
            if (rd_col + 1 >= ow)
            begin
                rd_col = 0;
                if (rd_row + 1 >= oh)
                begin
                    last = 1'b1;
                    rd_row = 0;
                end
                else
                    rd_row = rd_row + 1;
            end
            else
                rd_col = rd_col + 1;
            rotated_pixels.push_back('{pixel: plane_mem[addr], last: last});
            if (last)
            begin
                plane_phase = PH_LOAD;
                fill_count = '0;
            end
        end
    endfunction

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (rotated_pixels.size() == 0)
            begin
                $error("unexpected transfer: pixel_out=%h plane_end=%b", pixel_out, plane_end);
                fail_count++;
            end
            else
            begin
                want = rotated_pixels.pop_front();
                if (pixel_out !== want.pixel)
                begin
                    $error("pixel_out: expected %h, got %h", want.pixel, pixel_out);
                    fail_count++;
                end
                if (plane_end !== want.last)
                begin
                    $error("plane_end: expected %b, got %b", want.last, plane_end);
                    fail_count++;
                end
                pixels_checked++;
            end
        end
    end

    task automatic send_item(input logic rt, input logic [PIXEL_PORT_W-1:0] px);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        pixel_in <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        rotate_track(rt, px);
        items_sent++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_results();
        while (rotated_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_PLANE_COLS: cfg_cols = val;
            REG_PLANE_ROWS: cfg_rows = val;
            default:        cfg_mode = val[MODE_CFG_W-1:0];
        endcase
    endtask

    task automatic set_plane(input logic [SIDE_CFG_W-1:0] cols,
                             input logic [SIDE_CFG_W-1:0] rows,
                             input logic [MODE_CFG_W-1:0] mode);
        write_reg(REG_PLANE_COLS, cols);
        write_reg(REG_PLANE_ROWS, rows);
        write_reg(REG_ROTATE_MODE, CFG_DATA_W'(mode));
    endtask

    // Load one plane, then drain it; noise items land in the phase that ignores them.
    task automatic run_plane(input bit pause, input int noise_pct);
        int unsigned total;
        int unsigned i;
        total = eff_side(cfg_cols) * eff_side(cfg_rows);
        for (i = 0; i < total; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_item(REQ_PULL, $urandom);
            send_item(REQ_STORE, $urandom);
        end
        for (i = 0; i < total; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_item(REQ_STORE, $urandom);
            send_item(REQ_PULL, $urandom);
            if (pause && i == total / 2)
            begin
                drop_valid();
                wait_results();
            end
        end
        drop_valid();
        wait_results();
        planes_done++;
    endtask

    task automatic test_directed();
        // rotate mode left at its reset value
        write_reg(REG_PLANE_COLS, 9'd2);
        write_reg(REG_PLANE_ROWS, 9'd2);
        send_item(REQ_PULL, '1);
        send_item(REQ_STORE, '0);
        send_item(REQ_STORE, '1);
        send_item(REQ_STORE, 32'hA5A5_A5A5);
        send_item(REQ_STORE, 32'h5A5A_5A5A);
        send_item(REQ_PULL, '0);
        send_item(REQ_STORE, '1);
        send_item(REQ_PULL, '1);
        send_item(REQ_PULL, '0);
        send_item(REQ_PULL, '0);
        drop_valid();
        wait_results();
        planes_done++;
        set_plane(9'd3, 9'd1, ROT_RIGHT);
        run_plane(1'b0, 0);
        set_plane(9'd1, 9'd3, ROT_HALF);
        run_plane(1'b0, 0);
        set_plane(9'd0, 9'd0, ROT_SPARE);
        run_plane(1'b0, 0);
    endtask

    task automatic test_size_extremes();
        send_idle_pct = 0;
        stall_pct = 0;
        set_plane(9'd511, 9'd0, ROT_SPARE);
        run_plane(1'b0, 2);
    endtask

    task automatic test_drain_pause();
        send_idle_pct = 0;
        stall_pct = 0;
        set_plane(9'd4, 9'd3, ROT_RIGHT);
        run_plane(1'b1, 0);
    endtask

    task automatic test_random_planes(input int idle, input int stall, input int n_items);
        int start;
        send_idle_pct = idle;
        stall_pct = stall;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            set_plane(SIDE_CFG_W'($urandom_range(12)), SIDE_CFG_W'($urandom_range(12)),
                      MODE_CFG_W'($urandom_range(3)));
            run_plane($urandom_range(7) == 0, 8);
        end
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_size_extremes();
        test_drain_pause();
        test_random_planes(0, 0, PHASE_ITEMS);
        test_random_planes(86, 0, PHASE_ITEMS);
        test_random_planes(0, 86, PHASE_ITEMS);
        test_random_planes(11, 11, PHASE_ITEMS);
        wait_results();
        $display("run covered %0d planes, %0d input transfers, %0d rotated pixels checked",
                 planes_done, items_sent, pixels_checked);
        $display("left, right, half and spare modes; sides 1 to 256 with clamping; idle/stall mixes");
        if (fail_count == 0)
            $display("plane_rotate_90_180: match");
        else
            $display("plane_rotate_90_180: mismatch");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("plane_rotate_90_180: mismatch");
        $finish;
    end

endmodule
